### rtl/detector_pulse_shaper_chain_unit_assert.svh
// Assertion macros shared by the pulse shaper chain RTL.
`ifndef DETECTOR_PULSE_SHAPER_CHAIN_UNIT_ASSERT_SVH
`define DETECTOR_PULSE_SHAPER_CHAIN_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and masked while arst_n is low.
`define DPSC_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DPSC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Invariant that must hold at every edge outside reset.
`define DPSC_ASSERT_ALWAYS(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`endif

### rtl/dpsc_pkg.sv
// Package with widths, constants, types and helpers of the pulse shaper chain.
`timescale 1ns / 1ps
package dpsc_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int FRAC_BITS   = 16;

	localparam int STATE_W  = 48;
	localparam int DATA_W   = STATE_W + 1;
	localparam int SUM_W    = STATE_W + 2;
	localparam int HALF_W   = STATE_W / 2;
	localparam int COEF_W   = 32;
	localparam int PROD_W   = HALF_W + COEF_W;
	localparam int SAMPLE_W = 16;
	localparam int START_W  = 16;
	localparam int SLOW_W   = 16;
	localparam int CMP_W    = (COUNT_WIDTH > START_W) ? COUNT_WIDTH : START_W;
	localparam int PULSE_W  = STATE_W - FRAC_BITS;
	localparam int OSUM_W   = PULSE_W + 1;
	localparam int CFG_IDX_W = 2;
	localparam int NUM_CELLS = 6;
	localparam int CFG_SHIFT = 16;

	localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
	localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};

	// Filter constants at FRAC_BITS, rounded to nearest.
	localparam logic [COEF_W-1:0] K_FAST =
		COEF_W'(((64'd4 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [COEF_W-1:0] K_CR =
		COEF_W'(((64'd1250 << FRAC_BITS) + 64'd625) / 64'd1251);
	localparam logic [COEF_W-1:0] K_RC =
		COEF_W'(((64'd8 << FRAC_BITS) + 64'd11) / 64'd22);

	localparam logic [SLOW_W-1:0]  SLOW_COEFF_RST  = 16'd46811;
	localparam logic [COEF_W-1:0]  CHARGE_GAIN_RST = 32'd26214400;
	localparam logic [START_W-1:0] START_TICK_RST  = 16'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLOW_COEFF  = CFG_IDX_W'(0),
		REG_CHARGE_GAIN = CFG_IDX_W'(1),
		REG_START_TICK  = CFG_IDX_W'(2)
	} reg_index_t;

	// High-pass keeps the product, low-pass adds it to its state,
	// integrator accumulates it and hands on the increment.
	typedef enum logic [1:0] {
		MODE_HP  = 2'd0,
		MODE_LP  = 2'd1,
		MODE_INT = 2'd2
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
		logic       use_q16;
	} cell_ctl_t;

	localparam cell_ctl_t CELL_CTL [NUM_CELLS] = '{
		'{mode: MODE_HP,  use_q16: 1'b1},
		'{mode: MODE_LP,  use_q16: 1'b0},
		'{mode: MODE_INT, use_q16: 1'b1},
		'{mode: MODE_HP,  use_q16: 1'b0},
		'{mode: MODE_LP,  use_q16: 1'b0},
		'{mode: MODE_LP,  use_q16: 1'b0}
	};

	function automatic logic signed [STATE_W-1:0] sat_state(
		input logic signed [SUM_W-1:0] v
	);
		logic signed [STATE_W-1:0] r;
		if (v > SUM_W'(STATE_MAX)) begin
			r = STATE_MAX;
		end else if (v < SUM_W'(STATE_MIN)) begin
			r = STATE_MIN;
		end else begin
			r = STATE_W'(v);
		end
		return r;
	endfunction

endpackage

### rtl/dpsc_mulq.sv
// Four-stage signed by unsigned fixed-point multiplier with floor and saturation.
`timescale 1ns / 1ps
module dpsc_mulq
	import dpsc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic signed [STATE_W-1:0] in_data,
	input  logic [COEF_W-1:0]         coeff,
	input  logic                      use_q16,
	output logic                      out_valid,
	output logic signed [STATE_W-1:0] out_data
);

	typedef struct packed {
		logic [STATE_W-1:0] q;
		logic               ovf;
		logic               rem;
	} fold_t;

	// Recombines the two partial products for a right shift by s.
	function automatic fold_t fold(
		input logic [PROD_W-1:0] ph,
		input logic [PROD_W-1:0] pl,
		input int                s
	);
		fold_t             r;
		logic [PROD_W-1:0] t;
		t     = ph << (HALF_W - s);
		r.q   = STATE_W'(t) + STATE_W'(pl >> s);
		r.ovf = (ph >> (HALF_W - 1 + s)) != '0;
		r.rem = (pl & ((PROD_W'(1) << s) - PROD_W'(1))) != '0;
		return r;
	endfunction

	localparam logic [STATE_W-1:0] HALF_POINT = {1'b1, {(STATE_W-1){1'b0}}};

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic               neg_s1, neg_s2, neg_s3;
	logic [STATE_W-1:0] mag_s1;
	logic [PROD_W-1:0]  ph_s2, pl_s2;
	fold_t              fold_s3;
	logic signed [STATE_W-1:0] res_s4;
	fold_t              fold_c;
	logic signed [STATE_W-1:0] res_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_comb begin
		if (use_q16) begin
			fold_c = fold(ph_s2, pl_s2, CFG_SHIFT);
		end else begin
			fold_c = fold(ph_s2, pl_s2, FRAC_BITS);
		end
	end

	// Negative results round toward minus infinity: -(q + rem) = ~q + !rem.
	always_comb begin
		if (fold_s3.ovf) begin
			res_c = neg_s3 ? STATE_MIN : STATE_MAX;
		end else if (neg_s3) begin
			if (fold_s3.q > HALF_POINT || (fold_s3.q == HALF_POINT && fold_s3.rem)) begin
				res_c = STATE_MIN;
			end else begin
				res_c = ~fold_s3.q + STATE_W'(!fold_s3.rem);
			end
		end else begin
			res_c = fold_s3.q[STATE_W-1] ? STATE_MAX : fold_s3.q;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1  <= in_data[STATE_W-1];
		mag_s1  <= in_data[STATE_W-1] ? STATE_W'(-in_data) : STATE_W'(in_data);
		neg_s2  <= neg_s1;
		ph_s2   <= mag_s1[STATE_W-1:HALF_W] * coeff;
		pl_s2   <= mag_s1[HALF_W-1:0] * coeff;
		neg_s3  <= neg_s2;
		fold_s3 <= fold_c;
		res_s4  <= res_c;
	end

	assign out_valid = vld_s4;
	assign out_data  = res_s4;

endmodule

### rtl/dpsc_cell.sv
// One filter cell of the shaper chain: own state, shared-form update, neighbor output.
`timescale 1ns / 1ps
module dpsc_cell
	import dpsc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctl_t                ctl,
	input  logic [COEF_W-1:0]        coeff,
	input  logic                     clr,
	input  logic                     in_valid,
	input  logic signed [DATA_W-1:0] in_data,
	output logic                     out_valid,
	output logic signed [DATA_W-1:0] out_data
);

	logic signed [STATE_W-1:0] state_q, old_q;
	logic signed [STATE_W-1:0] pre_s1;
	logic                      vld_s1;
	logic                      prod_valid;
	logic signed [STATE_W-1:0] prod;
	logic                      vld_s6, vld_s7;
	logic signed [DATA_W-1:0]  out_s7;
	logic signed [SUM_W-1:0]   pre_sum, post_sum;
	logic signed [STATE_W-1:0] post_val;

	always_comb begin
		unique case (ctl.mode)
			MODE_HP:  pre_sum = SUM_W'(state_q) + SUM_W'(in_data);
			MODE_LP:  pre_sum = SUM_W'(in_data) - SUM_W'(state_q);
			MODE_INT: pre_sum = SUM_W'(in_data);
			default:  pre_sum = SUM_W'(in_data);
		endcase
	end

	dpsc_mulq u_mulq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s1),
		.in_data  (pre_s1),
		.coeff    (coeff),
		.use_q16  (ctl.use_q16),
		.out_valid(prod_valid),
		.out_data (prod)
	);

	assign post_sum = SUM_W'(state_q) + SUM_W'(prod);
	assign post_val = (ctl.mode == MODE_HP) ? prod : sat_state(post_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			state_q <= '0;
			old_q   <= '0;
		end else begin
			vld_s1 <= in_valid;
			vld_s6 <= prod_valid;
			vld_s7 <= vld_s6;
			if (clr) begin
				state_q <= '0;
				old_q   <= '0;
			end else if (prod_valid) begin
				state_q <= post_val;
				old_q   <= state_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		pre_s1 <= sat_state(pre_sum);
		if (ctl.mode == MODE_INT) begin
			out_s7 <= DATA_W'(state_q) - DATA_W'(old_q);
		end else begin
			out_s7 <= DATA_W'(state_q);
		end
	end

	assign out_valid = vld_s7;
	assign out_data  = out_s7;

endmodule

### rtl/detector_pulse_shaper_chain_unit.sv
// Top level of the detector pulse shaper chain: config, sample counter, cell row, output.
`timescale 1ns / 1ps
//
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+------------------------------------
// config   | in        | cfg_we (no wait)    | cfg_index[1:0], cfg_data[31:0]
// input    | in        | in_valid / in_ready | restart, base_sample[15:0] signed
// output   | out       | out_valid/out_ready | sample[15:0] signed
//
// One beat is in flight at a time. It crosses six filter cells, each with pre-add,
// four multiplier stages, state update and hand-off, then a truncation stage and
// the output register. The next beat is accepted once the result has moved into
// the output register; while that register is full, the move waits.
// The output register decouples the sides: a new beat is taken while the previous
// result still waits; a full output register stalls the chain only at its end.
// Reset clears the counter and all filter state, the same as a restart beat,
// and loads the register defaults.
module detector_pulse_shaper_chain_unit
	import dpsc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [COEF_W-1:0]          cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       restart,
	input  logic signed [SAMPLE_W-1:0] base_sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] sample
);

	`include "detector_pulse_shaper_chain_unit_assert.svh"

	localparam logic [COUNT_WIDTH-1:0]    COUNT_MAX = '1;
	localparam logic [COUNT_WIDTH-1:0]    TICK_ONE  = COUNT_WIDTH'(1);
	localparam logic signed [DATA_W-1:0] STEP_ONE  = DATA_W'(1) << FRAC_BITS;
	localparam logic signed [OSUM_W-1:0] OUT_MAX   = OSUM_W'(16'sh7fff);
	localparam logic signed [OSUM_W-1:0] OUT_MIN   = -OSUM_W'(17'sh08000);

	// Configuration registers.
	logic [SLOW_W-1:0]  slow_coeff_q;
	logic [COEF_W-1:0]  charge_gain_q;
	logic [START_W-1:0] start_tick_q;

	// Sequencing state.
	logic                          busy_q;
	logic [COUNT_WIDTH-1:0]        tick_q;
	logic                          prev_step_q;
	logic signed [SAMPLE_W-1:0]    base_q;
	logic                          feed_valid_q;
	logic signed [DATA_W-1:0]      feed_data_q;
	logic                          pulse_valid_q;
	logic signed [PULSE_W-1:0]     pulse_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_W-1:0]    out_q;

	logic                          in_fire;
	logic                          move;
	logic [COUNT_WIDTH-1:0]        tick_eff;
	logic                          prev_eff;
	logic                          step;
	logic signed [DATA_W-1:0]      feed_c;
	logic                          cell_clr;

	logic [NUM_CELLS:0]            c_valid;
	logic signed [DATA_W-1:0]      c_data [NUM_CELLS+1];
	logic [COEF_W-1:0]             coef [NUM_CELLS];

	logic signed [STATE_W-1:0]     lp_last;
	logic signed [STATE_W-1:0]     lp_shift;
	logic                          lp_round;
	logic signed [OSUM_W-1:0]      out_sum;
	logic signed [SAMPLE_W-1:0]    out_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_coeff_q  <= SLOW_COEFF_RST;
			charge_gain_q <= CHARGE_GAIN_RST;
			start_tick_q  <= START_TICK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLOW_COEFF:  slow_coeff_q  <= cfg_data[SLOW_W-1:0];
				REG_CHARGE_GAIN: charge_gain_q <= cfg_data;
				REG_START_TICK:  start_tick_q  <= cfg_data[START_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !busy_q;
	assign in_fire  = in_valid && in_ready;
	assign move     = pulse_valid_q && (!out_valid_q || out_ready);
	assign cell_clr = in_fire && restart;

	// A restart beat runs as tick zero with all filters cleared.
	assign tick_eff = restart ? '0 : tick_q;
	assign prev_eff = restart ? 1'b0 : prev_step_q;
	assign step     = CMP_W'(tick_eff) >= CMP_W'(start_tick_q);

	// Input of the slow stage is the step edge: +1, -1 or nothing.
	always_comb begin
		if (step && !prev_eff) begin
			feed_c = STEP_ONE;
		end else if (!step && prev_eff) begin
			feed_c = -STEP_ONE;
		end else begin
			feed_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			tick_q        <= '0;
			prev_step_q   <= 1'b0;
			feed_valid_q  <= 1'b0;
			pulse_valid_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			feed_valid_q <= in_fire;
			if (in_fire) begin
				busy_q      <= 1'b1;
				prev_step_q <= step;
				tick_q      <= (tick_eff == COUNT_MAX) ? tick_eff : tick_eff + TICK_ONE;
			end else if (move) begin
				busy_q <= 1'b0;
			end
			if (c_valid[NUM_CELLS]) begin
				pulse_valid_q <= 1'b1;
			end else if (move) begin
				pulse_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		coef[0] = COEF_W'(slow_coeff_q);
		coef[1] = K_FAST;
		coef[2] = charge_gain_q;
		coef[3] = K_CR;
		coef[4] = K_RC;
		coef[5] = K_RC;
	end

	assign c_valid[0] = feed_valid_q;
	assign c_data[0]  = feed_data_q;

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		dpsc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (CELL_CTL[i]),
			.coeff    (coef[i]),
			.clr      (cell_clr),
			.in_valid (c_valid[i]),
			.in_data  (c_data[i]),
			.out_valid(c_valid[i+1]),
			.out_data (c_data[i+1])
		);
	end

	// Truncate the last low-pass toward zero: floor, then add one back when a
	// negative value had fraction bits set.
	assign lp_last  = STATE_W'(c_data[NUM_CELLS]);
	assign lp_shift = lp_last >>> FRAC_BITS;
	assign lp_round = lp_last[STATE_W-1] && (lp_last[FRAC_BITS-1:0] != '0);

	assign out_sum = OSUM_W'(base_q) + OSUM_W'(pulse_q);
	always_comb begin
		if (out_sum > OUT_MAX) begin
			out_sat = SAMPLE_W'(OUT_MAX);
		end else if (out_sum < OUT_MIN) begin
			out_sat = SAMPLE_W'(OUT_MIN);
		end else begin
			out_sat = SAMPLE_W'(out_sum);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			base_q      <= base_sample;
			feed_data_q <= feed_c;
		end
		if (c_valid[NUM_CELLS]) begin
			pulse_q <= PULSE_W'(lp_shift) + PULSE_W'(lp_round);
		end
		if (move) begin
			out_q <= out_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = out_q;

	`DPSC_ASSERT_ALWAYS(a_one_in_flight, $onehot0({c_valid, pulse_valid_q}),
		"more than one beat inside the cell row")
	`DPSC_ASSERT_IMP(a_idle_empty, !busy_q, (c_valid == '0) && !pulse_valid_q,
		"cell row or truncation stage active while idle")
	`DPSC_ASSERT_NEXT(a_restart_tick, in_valid && in_ready && restart, tick_q == TICK_ONE,
		"restart beat did not restart the sample counter")

endmodule
